// File: hw/rtl/stn_pkg.sv
// Shared types, constants and helper functions for the source tokenizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package stn_pkg;

  // Width of the internal position, line and column counters
  localparam int CW      = 16;
  // Most tokens a single input transaction can produce
  localparam int MAX_RES = 3;

  typedef logic [CW-1:0] cnt_t;

  localparam cnt_t CNT_MAX = '1;
  localparam cnt_t CNT_ONE = cnt_t'(1);
  localparam cnt_t CNT_TWO = cnt_t'(2);

  // Token kinds
  localparam logic [4:0] K_EOF     = 5'd0;
  localparam logic [4:0] K_IDENT   = 5'd1;
  localparam logic [4:0] K_IF      = 5'd2;
  localparam logic [4:0] K_ELSE    = 5'd3;
  localparam logic [4:0] K_FOR     = 5'd4;
  localparam logic [4:0] K_NUMBER  = 5'd5;
  localparam logic [4:0] K_STRING  = 5'd6;
  localparam logic [4:0] K_LPAREN  = 5'd7;
  localparam logic [4:0] K_RPAREN  = 5'd8;
  localparam logic [4:0] K_LBRACE  = 5'd9;
  localparam logic [4:0] K_RBRACE  = 5'd10;
  localparam logic [4:0] K_COMMA   = 5'd11;
  localparam logic [4:0] K_SEMI    = 5'd12;
  localparam logic [4:0] K_PLUS    = 5'd13;
  localparam logic [4:0] K_MINUS   = 5'd14;
  localparam logic [4:0] K_STAR    = 5'd15;
  localparam logic [4:0] K_SLASH   = 5'd16;
  localparam logic [4:0] K_ASSIGN  = 5'd17;
  localparam logic [4:0] K_EQ      = 5'd18;
  localparam logic [4:0] K_NEQ     = 5'd19;
  localparam logic [4:0] K_LT      = 5'd20;
  localparam logic [4:0] K_LE      = 5'd21;
  localparam logic [4:0] K_GT      = 5'd22;
  localparam logic [4:0] K_GE      = 5'd23;
  localparam logic [4:0] K_UNKNOWN = 5'd24;

  // Error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_BANG    = 2'd1;
  localparam logic [1:0] ERR_UNTERM  = 2'd2;

  // Keyword text, first character in the lowest byte
  localparam logic [63:0] KW_TXT [3] = '{
    {16'h0000, "fi_ecw"},
    "esle_ecw",
    {8'h00, "rof_ecw"}
  };
  localparam logic [3:0] KW_LEN [3] = '{4'd6, 4'd8, 4'd7};

  typedef enum logic [11:0] {
    PH_SKIP    = 12'b0000_0000_0001,
    PH_IDENT   = 12'b0000_0000_0010,
    PH_NUM     = 12'b0000_0000_0100,
    PH_DOT     = 12'b0000_0000_1000,
    PH_FRAC    = 12'b0000_0001_0000,
    PH_STR     = 12'b0000_0010_0000,
    PH_SLASH   = 12'b0000_0100_0000,
    PH_COMMENT = 12'b0000_1000_0000,
    PH_EQ      = 12'b0001_0000_0000,
    PH_BANG    = 12'b0010_0000_0000,
    PH_LT      = 12'b0100_0000_0000,
    PH_GT      = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] byte_in;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] token_line;
    logic [15:0] token_column;
    logic [15:0] text_offset;
    logic [15:0] text_length;
    logic [1:0]  error_code;
    logic        last_of_run;
  } out_item_t;

  // Tokens handed from the step logic to the result queue in one cycle
  typedef struct packed {
    logic [1:0]                  cnt;
    out_item_t [MAX_RES-1:0]     items;
  } push_t;

  function automatic cnt_t sat_inc(cnt_t x);
    return (x == CNT_MAX) ? x : x + CNT_ONE;
  endfunction

  function automatic cnt_t sat_dec(cnt_t x);
    return (x == '0) ? x : x - CNT_ONE;
  endfunction

  function automatic cnt_t cdiff(cnt_t a, cnt_t b);
    return (a >= b) ? a - b : '0;
  endfunction

  // Clamp a counter value into a 16-bit result field
  function automatic logic [15:0] out16(cnt_t x);
    logic [47:0] xe;
    xe = 48'(x);
    return (xe > 48'hFFFF) ? 16'hFFFF : xe[15:0];
  endfunction

  function automatic out_item_t mk_tok(logic [4:0] kind, cnt_t line, cnt_t col,
                                       cnt_t off, cnt_t len, logic [1:0] err);
    out_item_t t;
    t.token_kind   = kind;
    t.token_line   = out16(line);
    t.token_column = out16(col);
    t.text_offset  = out16(off);
    t.text_length  = out16(len);
    t.error_code   = err;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic [4:0] single_kind(logic [7:0] b);
    logic [4:0] k;
    unique case (b)
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      ",":     k = K_COMMA;
      ";":     k = K_SEMI;
      "+":     k = K_PLUS;
      "-":     k = K_MINUS;
      "*":     k = K_STAR;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  // Drop keyword candidates that do not match byte b at position idx
  function automatic logic [2:0] kw_step(logic [2:0] m, cnt_t idx, logic [7:0] b);
    logic [2:0] r;
    r = m;
    for (int k = 0; k < 3; k++) begin
      if (idx >= cnt_t'(KW_LEN[k])) begin
        r[k] = 1'b0;
      end else if (KW_TXT[k][8*idx[2:0] +: 8] != b) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/stn_core.sv
// Input register, tokenizer state and the per-byte step logic.
// Depends on stn_pkg; feeds up to three tokens per transaction to stn_queue.
`timescale 1ns / 1ps

module stn_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  stn_pkg::in_item_t in_data,
  input  logic             room,
  output stn_pkg::push_t   push
);
  import stn_pkg::*;

  logic       in_v_r;
  in_item_t   in_item_r;
  logic       adv;
  logic [7:0] b;

  phase_t     phase_r, phase_nxt;
  cnt_t       bp_r, bp_nxt;
  cnt_t       ln_r, ln_nxt;
  cnt_t       col_r, col_nxt;
  cnt_t       sp_r, sp_nxt;
  cnt_t       sl_r, sl_nxt;
  cnt_t       sc_r, sc_nxt;
  logic [2:0] km_r, km_nxt;

  // Outcome of starting a fresh token at the current byte
  phase_t     f_phase;
  cnt_t       f_bp, f_ln, f_col, f_sp, f_sl, f_sc;
  logic [2:0] f_km;
  out_item_t  f_tok;
  logic       f_v;

  cnt_t       len_cur;
  cnt_t       body;
  logic [4:0] ident_kind;
  logic [4:0] op_one, op_two;
  logic [1:0] op_err;
  logic       take_fresh;

  // Token slots in emission order: pending, split dot, fresh or eof
  out_item_t  s_tok [MAX_RES];
  logic       s_v   [MAX_RES];
  out_item_t  c_items [MAX_RES];
  logic [1:0] n;

  assign b        = in_item_r.byte_in;
  assign adv      = in_v_r & room;
  assign in_stall = in_v_r & ~room;

  // Hold the incoming transaction until the step logic takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
  end

  // Start of a new token, or skip of whitespace
  always_comb begin
    f_phase = PH_SKIP;
    f_bp    = sat_inc(bp_r);
    f_ln    = ln_r;
    f_col   = sat_inc(col_r);
    f_sp    = sp_r;
    f_sl    = sl_r;
    f_sc    = sc_r;
    f_km    = km_r;
    f_tok   = mk_tok(single_kind(b), ln_r, col_r, bp_r, CNT_ONE, ERR_NONE);
    f_v     = 1'b0;
    priority if (b == " " || b == 8'h09 || b == 8'h0D) begin
      f_phase = PH_SKIP;
    end else if (b == 8'h0A) begin
      f_ln  = sat_inc(ln_r);
      f_col = CNT_ONE;
    end else begin
      f_sp = bp_r;
      f_sl = ln_r;
      f_sc = col_r;
      priority if (is_alpha(b)) begin
        f_km    = kw_step(3'b111, '0, b);
        f_phase = PH_IDENT;
      end else if (is_digit(b)) begin
        f_phase = PH_NUM;
      end else if (b == 8'h22) begin
        f_phase = PH_STR;
      end else if (b == "/") begin
        f_phase = PH_SLASH;
      end else if (b == "=") begin
        f_phase = PH_EQ;
      end else if (b == "!") begin
        f_phase = PH_BANG;
      end else if (b == "<") begin
        f_phase = PH_LT;
      end else if (b == ">") begin
        f_phase = PH_GT;
      end else begin
        f_v = 1'b1;
      end
    end
  end

  // Classify the pending identifier and operator candidates
  assign len_cur = cdiff(bp_r, sp_r);
  assign body    = sat_inc(sp_r);

  always_comb begin
    priority if (km_r[0] && len_cur == cnt_t'(KW_LEN[0])) begin
      ident_kind = K_IF;
    end else if (km_r[1] && len_cur == cnt_t'(KW_LEN[1])) begin
      ident_kind = K_ELSE;
    end else if (km_r[2] && len_cur == cnt_t'(KW_LEN[2])) begin
      ident_kind = K_FOR;
    end else begin
      ident_kind = K_IDENT;
    end
  end

  always_comb begin
    op_err = ERR_NONE;
    unique case (phase_r)
      PH_EQ: begin
        op_one = K_ASSIGN;
        op_two = K_EQ;
      end
      PH_BANG: begin
        op_one = K_UNKNOWN;
        op_two = K_NEQ;
        op_err = ERR_BANG;
      end
      PH_LT: begin
        op_one = K_LT;
        op_two = K_LE;
      end
      default: begin
        op_one = K_GT;
        op_two = K_GE;
      end
    endcase
  end

  // Step the phase machine by one transaction
  always_comb begin
    phase_nxt  = phase_r;
    bp_nxt     = bp_r;
    ln_nxt     = ln_r;
    col_nxt    = col_r;
    sp_nxt     = sp_r;
    sl_nxt     = sl_r;
    sc_nxt     = sc_r;
    km_nxt     = km_r;
    take_fresh = 1'b0;
    s_v[0]     = 1'b0;
    s_v[1]     = 1'b0;
    s_v[2]     = 1'b0;
    s_tok[0]   = mk_tok(K_NUMBER, sl_r, sc_r, sp_r, len_cur, ERR_NONE);
    s_tok[1]   = mk_tok(K_UNKNOWN, ln_r, sat_dec(col_r), sat_dec(bp_r), CNT_ONE, ERR_NONE);
    s_tok[2]   = mk_tok(K_EOF, ln_r, col_r, bp_r, '0, ERR_NONE);

    if (in_item_r.mode) begin
      // flush the pending token, then eof, then return to reset values
      unique case (phase_r)
        PH_IDENT: begin
          s_v[0]   = 1'b1;
          s_tok[0] = mk_tok(ident_kind, sl_r, sc_r, sp_r, len_cur, ERR_NONE);
        end
        PH_NUM, PH_FRAC: begin
          s_v[0] = 1'b1;
        end
        PH_DOT: begin
          s_v[0]   = 1'b1;
          s_v[1]   = 1'b1;
          s_tok[0] = mk_tok(K_NUMBER, sl_r, sc_r, sp_r, sat_dec(len_cur), ERR_NONE);
        end
        PH_STR: begin
          s_v[0]   = 1'b1;
          s_tok[0] = mk_tok(K_UNKNOWN, sl_r, sc_r, sp_r, '0, ERR_UNTERM);
        end
        PH_SLASH: begin
          s_v[0]   = 1'b1;
          s_tok[0] = mk_tok(K_SLASH, sl_r, sc_r, sp_r, CNT_ONE, ERR_NONE);
        end
        PH_EQ, PH_BANG, PH_LT, PH_GT: begin
          s_v[0]   = 1'b1;
          s_tok[0] = mk_tok(op_one, sl_r, sc_r, sp_r, CNT_ONE, op_err);
        end
        default: begin
          s_v[0] = 1'b0;
        end
      endcase
      s_v[2]    = 1'b1;
      phase_nxt = PH_SKIP;
      bp_nxt    = '0;
      ln_nxt    = CNT_ONE;
      col_nxt   = CNT_ONE;
      sp_nxt    = '0;
      sl_nxt    = CNT_ONE;
      sc_nxt    = CNT_ONE;
      km_nxt    = 3'b111;
    end else begin
      unique case (phase_r)
        PH_IDENT: begin
          if (is_alpha(b) || is_digit(b)) begin
            km_nxt  = kw_step(km_r, len_cur, b);
            bp_nxt  = sat_inc(bp_r);
            col_nxt = sat_inc(col_r);
          end else begin
            s_v[0]     = 1'b1;
            s_tok[0]   = mk_tok(ident_kind, sl_r, sc_r, sp_r, len_cur, ERR_NONE);
            take_fresh = 1'b1;
          end
        end
        PH_NUM, PH_FRAC: begin
          if (is_digit(b)) begin
            bp_nxt  = sat_inc(bp_r);
            col_nxt = sat_inc(col_r);
          end else if (b == "." && phase_r == PH_NUM) begin
            phase_nxt = PH_DOT;
            bp_nxt    = sat_inc(bp_r);
            col_nxt   = sat_inc(col_r);
          end else begin
            s_v[0]     = 1'b1;
            take_fresh = 1'b1;
          end
        end
        PH_DOT: begin
          if (is_digit(b)) begin
            phase_nxt = PH_FRAC;
            bp_nxt    = sat_inc(bp_r);
            col_nxt   = sat_inc(col_r);
          end else begin
            // the dot was not a decimal point: split it off
            s_v[0]     = 1'b1;
            s_v[1]     = 1'b1;
            s_tok[0]   = mk_tok(K_NUMBER, sl_r, sc_r, sp_r, sat_dec(len_cur), ERR_NONE);
            take_fresh = 1'b1;
          end
        end
        PH_STR: begin
          if (b == 8'h22) begin
            s_v[0]    = 1'b1;
            s_tok[0]  = mk_tok(K_STRING, sl_r, sc_r, body, cdiff(bp_r, body), ERR_NONE);
            phase_nxt = PH_SKIP;
            bp_nxt    = sat_inc(bp_r);
            col_nxt   = sat_inc(col_r);
          end else if (b == 8'h0A) begin
            bp_nxt  = sat_inc(bp_r);
            ln_nxt  = sat_inc(ln_r);
            col_nxt = CNT_ONE;
          end else begin
            bp_nxt  = sat_inc(bp_r);
            col_nxt = sat_inc(col_r);
          end
        end
        PH_SLASH: begin
          if (b == "/") begin
            phase_nxt = PH_COMMENT;
            bp_nxt    = sat_inc(bp_r);
            col_nxt   = sat_inc(col_r);
          end else begin
            s_v[0]     = 1'b1;
            s_tok[0]   = mk_tok(K_SLASH, sl_r, sc_r, sp_r, CNT_ONE, ERR_NONE);
            take_fresh = 1'b1;
          end
        end
        PH_COMMENT: begin
          if (b == 8'h0A) begin
            take_fresh = 1'b1;
          end else begin
            bp_nxt  = sat_inc(bp_r);
            col_nxt = sat_inc(col_r);
          end
        end
        PH_EQ, PH_BANG, PH_LT, PH_GT: begin
          s_v[0] = 1'b1;
          if (b == "=") begin
            s_tok[0]  = mk_tok(op_two, sl_r, sc_r, sp_r, CNT_TWO, ERR_NONE);
            phase_nxt = PH_SKIP;
            bp_nxt    = sat_inc(bp_r);
            col_nxt   = sat_inc(col_r);
          end else begin
            s_tok[0]   = mk_tok(op_one, sl_r, sc_r, sp_r, CNT_ONE, op_err);
            take_fresh = 1'b1;
          end
        end
        default: begin
          take_fresh = 1'b1;
        end
      endcase

      if (take_fresh) begin
        phase_nxt = f_phase;
        bp_nxt    = f_bp;
        ln_nxt    = f_ln;
        col_nxt   = f_col;
        sp_nxt    = f_sp;
        sl_nxt    = f_sl;
        sc_nxt    = f_sc;
        km_nxt    = f_km;
        s_v[2]    = f_v;
        s_tok[2]  = f_tok;
      end
    end
  end

  // Pack the live slots in order and mark the final one
  always_comb begin
    n = 2'd0;
    for (int i = 0; i < MAX_RES; i++) begin
      c_items[i] = s_tok[i];
    end
    for (int i = 0; i < MAX_RES; i++) begin
      if (s_v[i]) begin
        c_items[n] = s_tok[i];
        n = n + 2'd1;
      end
    end
    if (n != 2'd0) begin
      c_items[2'(n - 2'd1)].last_of_run = 1'b1;
    end
    push.cnt = adv ? n : 2'd0;
    for (int i = 0; i < MAX_RES; i++) begin
      push.items[i] = c_items[i];
    end
  end

  // Advance the tokenizer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      bp_r    <= '0;
      ln_r    <= CNT_ONE;
      col_r   <= CNT_ONE;
      sp_r    <= '0;
      sl_r    <= CNT_ONE;
      sc_r    <= CNT_ONE;
      km_r    <= 3'b111;
    end else if (adv) begin
      phase_r <= phase_nxt;
      bp_r    <= bp_nxt;
      ln_r    <= ln_nxt;
      col_r   <= col_nxt;
      sp_r    <= sp_nxt;
      sl_r    <= sl_nxt;
      sc_r    <= sc_nxt;
      km_r    <= km_nxt;
    end
  end

endmodule

// File: hw/rtl/stn_queue.sv
// Result queue: takes up to three tokens a cycle, delivers one a cycle unless stalled.
// Depends on stn_pkg.
`timescale 1ns / 1ps

module stn_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  stn_pkg::push_t    push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output stn_pkg::out_item_t out_data
);
  import stn_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  out_item_t          mem_r [QDEPTH];
  logic [QAW-1:0]     wp_r, wp_nxt;
  logic [QAW-1:0]     rp_r, rp_nxt;
  logic [QAW:0]       cnt_r, cnt_nxt;
  logic               pop;

  // Accept a new step only when a full burst of tokens still fits
  assign room      = cnt_r <= (QAW+1)'(QDEPTH - MAX_RES);
  assign out_valid = cnt_r != '0;
  assign out_data  = mem_r[rp_r];
  assign pop       = out_valid && !out_stall;

  assign wp_nxt  = wp_r + QAW'(push.cnt);
  assign rp_nxt  = rp_r + QAW'(pop);
  assign cnt_nxt = cnt_r + (QAW+1)'(push.cnt) - (QAW+1)'(pop);

  // Write the burst into free slots; the head is never overwritten
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (i < int'(push.cnt)) begin
        mem_r[wp_r + QAW'(i)] <= push.items[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hw/rtl/source_tokenizer.sv
// Top level of the streaming source tokenizer.
// Depends on stn_pkg, stn_core and stn_queue.
//
//   Channel  Direction  Handshake            Transaction
//   in_      input      in_valid / in_stall  one source byte or end of source
//   out_     output     out_valid / out_stall one token
//
// A byte is taken every cycle while each byte yields at most one token and
// out_stall is low. A byte that closes tokens yields up to three; the
// four-entry result queue drains one token per cycle while out_stall is low
// and in_stall rises until three slots are free. Each token passes the input
// register, then the result queue. Synchronous active-low reset empties both
// stages and returns line and column to one. out_stall holds the head token.
`timescale 1ns / 1ps

module source_tokenizer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  stn_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output stn_pkg::out_item_t out_data
);
  import stn_pkg::*;

  push_t push;
  logic  room;

  // Step logic and tokenizer state
  stn_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .room     (room),
    .push     (push)
  );

  // Token queue towards the output channel
  stn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: hw/rtl/stn_checker.sv
// Port-level checks for the source tokenizer, bound to the top level.
// Depends on stn_pkg and source_tokenizer.
`timescale 1ns / 1ps

module stn_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input stn_pkg::out_item_t out_data
);
  import stn_pkg::*;

  // A stalled token stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("token changed while stalled");

  // Eof is empty and always closes its transaction
  a_eof: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.token_kind == K_EOF |->
      out_data.text_length == 16'd0 && out_data.error_code == ERR_NONE &&
      out_data.last_of_run)
    else $error("malformed eof token");

  // Error tokens are unknown kind with the fixed length for their code
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error_code != ERR_NONE |->
      out_data.token_kind == K_UNKNOWN &&
      ((out_data.error_code == ERR_BANG && out_data.text_length == 16'd1) ||
       (out_data.error_code == ERR_UNTERM && out_data.text_length == 16'd0)))
    else $error("malformed error token");

  // Lines and columns count from one
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.token_line != 16'd0 && out_data.token_column != 16'd0)
    else $error("zero line or column");

  // The input side is free straight after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !in_stall || !in_valid || in_stall == 1'b0)
    else $error("input stalled after reset");

endmodule

bind source_tokenizer stn_checker u_chk (.*);
